// ===== rtl/sorted_table_binary_search_defines.svh =====
// assertion macros shared by the search block rtl
// no dependencies, included by the files that carry assertions
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// same-cycle implication under the async active-low reset
`define STBS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication under the async active-low reset
`define STBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== rtl/stbs_pkg.sv =====
// shared types and constants of the sorted table search block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

    // fixed field widths
    localparam int POS_W   = 11;
    localparam int BOUND_W = 12;
    localparam int ADDR_W  = 10;
    localparam int FIELD_W = 32;

    // action codes
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // table port strobes from the sequencer
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } tbl_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_table_binary_search.sv =====
// top level of the sorted table search block
// uses stbs_pkg, stbs_table and stbs_ctrl
`timescale 1ns / 1ps
`default_nettype none

// A transaction is taken when start is high and busy is low. A write transaction
// (action 0) stores entry_value at entry_addr in that same cycle, gives no result
// and leaves busy low. A search transaction bisects [range_lo, range_hi) for key:
// each probe is one registered read of the table (S_PROBE) followed by one signed
// compare (S_CMP); a miss ends in one more S_PROBE that finds the range empty. The
// number of probes P is at most floor(log2(n))+1 for a range of n entries. The
// result shows on found and position for exactly one cycle with done high; the
// receiver cannot stall it, so it must take the result in that cycle.
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic                                 action,
    input  wire logic [stbs_pkg::ADDR_W-1:0]          entry_addr,
    input  wire logic signed [stbs_pkg::FIELD_W-1:0]  entry_value,
    input  wire logic [stbs_pkg::ADDR_W-1:0]          range_lo,
    input  wire logic [stbs_pkg::POS_W-1:0]           range_hi,
    input  wire logic signed [stbs_pkg::FIELD_W-1:0]  key,
    output logic                                      done,
    output logic                                      found,
    output logic signed [stbs_pkg::POS_W-1:0]         position
);
    import stbs_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    tbl_ctrl_t                 tbl_ctrl;
    logic [AW-1:0]             wr_addr;
    logic signed [VALUE_WIDTH-1:0] wr_data;
    logic [AW-1:0]             rd_addr;
    logic signed [VALUE_WIDTH-1:0] rd_data;

    assign wr_addr = AW'(entry_addr);
    assign wr_data = VALUE_WIDTH'(entry_value);

    stbs_table #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_table (
        .clk     (clk),
        .ctrl    (tbl_ctrl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    stbs_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .action     (action),
        .entry_addr (entry_addr),
        .range_lo   (range_lo),
        .range_hi   (range_hi),
        .key        (key),
        .rd_data    (rd_data),
        .tbl_ctrl   (tbl_ctrl),
        .rd_addr    (rd_addr),
        .busy       (busy),
        .done       (done),
        .found      (found),
        .position   (position)
    );

endmodule

`default_nettype wire

// ===== rtl/stbs_table.sv =====
// table storage: one write port, one registered read port
// uses stbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module stbs_table #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                    clk,
    input  wire stbs_pkg::tbl_ctrl_t     ctrl,
    input  wire logic [AW-1:0]           wr_addr,
    input  wire logic signed [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]           rd_addr,
    output logic signed [WIDTH-1:0]      rd_data
);
    import stbs_pkg::*;

    logic signed [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stbs_ctrl.sv =====
// probe sequencer: bounds, midpoint, shared comparator, result registers
// uses stbs_pkg and the assertion macros header
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_table_binary_search_defines.svh"

module stbs_ctrl #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic                                  action,
    input  wire logic [stbs_pkg::ADDR_W-1:0]           entry_addr,
    input  wire logic [stbs_pkg::ADDR_W-1:0]           range_lo,
    input  wire logic [stbs_pkg::POS_W-1:0]            range_hi,
    input  wire logic signed [stbs_pkg::FIELD_W-1:0]   key,
    input  wire logic signed [VALUE_WIDTH-1:0]         rd_data,
    output stbs_pkg::tbl_ctrl_t                        tbl_ctrl,
    output logic [AW-1:0]                              rd_addr,
    output logic                                       busy,
    output logic                                       done,
    output logic                                       found,
    output logic signed [stbs_pkg::POS_W-1:0]          position
);
    import stbs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CMP
    } state_t;

    state_t                    state_reg, state_next;
    logic signed [BOUND_W-1:0] p_reg, p_next;
    logic signed [BOUND_W-1:0] q_reg, q_next;
    logic [BOUND_W-1:0]        mid_reg, mid_next;
    logic signed [VALUE_WIDTH-1:0] key_reg, key_next;
    logic                      done_reg, done_next;
    logic                      found_reg, found_next;
    logic signed [POS_W-1:0]   pos_reg, pos_next;

    logic                      accept;
    logic [POS_W-1:0]          hi_sat;
    logic [BOUND_W:0]          mid_sum;
    logic [BOUND_W-1:0]        mid;

    assign accept  = start && (state_reg == S_IDLE);
    assign hi_sat  = (int'(range_hi) > TABLE_DEPTH) ? POS_W'(TABLE_DEPTH) : range_hi;
    // both bounds are non-negative whenever a probe is issued
    assign mid_sum = (BOUND_W+1)'($unsigned(p_reg)) + (BOUND_W+1)'($unsigned(q_reg));
    assign mid     = mid_sum[BOUND_W:1];
    assign rd_addr = AW'(mid);

    always_comb
    begin
        tbl_ctrl.wr_en = accept && (action == ACT_WRITE) && (int'(entry_addr) < TABLE_DEPTH);
        tbl_ctrl.rd_en = (state_reg == S_PROBE) && (p_reg <= q_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        pos_next   = pos_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (action == ACT_SEARCH))
                begin
                    p_next     = signed'({2'b00, range_lo});
                    q_next     = signed'({1'b0, hi_sat}) - BOUND_W'(1);
                    key_next   = VALUE_WIDTH'(key);
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (p_reg <= q_reg)
                begin
                    mid_next   = mid;
                    state_next = S_CMP;
                end
                else
                begin
                    // range exhausted: q is the greatest index below key
                    done_next  = 1'b1;
                    found_next = 1'b0;
                    pos_next   = q_reg[POS_W-1:0];
                    state_next = S_IDLE;
                end
            end
            S_CMP:
            begin
                priority if (rd_data < key_reg)
                begin
                    p_next     = signed'(mid_reg + BOUND_W'(1));
                    state_next = S_PROBE;
                end
                else if (rd_data > key_reg)
                begin
                    q_next     = signed'(mid_reg - BOUND_W'(1));
                    state_next = S_PROBE;
                end
                else
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    pos_next   = signed'(mid_reg[POS_W-1:0]);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            p_reg     <= '0;
            q_reg     <= '0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            p_reg     <= p_next;
            q_reg     <= q_next;
            done_reg  <= done_next;
            found_reg <= found_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg <= mid_next;
        key_reg <= key_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign found    = found_reg;
    assign position = pos_reg;

    `STBS_ASSERT_SAME(a_done_when_idle, clk, rst_n, done_reg, state_reg == S_IDLE)
    `STBS_ASSERT_NEXT(a_search_goes_busy, clk, rst_n, accept && (action == ACT_SEARCH), busy)
    `STBS_ASSERT_SAME(a_cmp_after_probe, clk, rst_n, state_reg == S_CMP,
                      $past(state_reg) == S_PROBE)
    `STBS_ASSERT_SAME(a_hit_from_cmp, clk, rst_n, done_reg && found_reg,
                      $past(state_reg) == S_CMP)
    `STBS_ASSERT_SAME(a_no_write_when_busy, clk, rst_n, busy, !tbl_ctrl.wr_en)

endmodule

`default_nettype wire
